FILE: hdl/fsq_pkg.sv
// Shared constants and types for the per-letter filled square counter.
`timescale 1ns / 1ps

package fsq_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_SIDE_DEF = 4096;
  localparam int ALPHABET_DEF = 26;

  // Fixed field widths.
  localparam int LETTER_W    = 5;
  localparam int TOTAL_W     = 40;
  localparam int GRID_SIDE_W = 13;
  localparam int LETTERS_W   = 5;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register indexes, decoded from paddr[2].
  localparam logic REG_GRID_SIDE = 1'b0;
  localparam logic REG_LETTERS   = 1'b1;

  // Request from the cell pipeline to the totals block.
  typedef struct packed {
    logic                add;
    logic                last;
    logic [LETTER_W-1:0] letter;
  } tot_req_t;

endpackage

FILE: hdl/fsq_line.sv
// Previous-row line buffer with a registered read port and write-to-read forwarding.
`timescale 1ns / 1ps

module fsq_line
  import fsq_pkg::*;
#(
  parameter int DEPTH = MAX_SIDE_DEF,
  parameter int AW    = $clog2(MAX_SIDE_DEF),
  parameter int SW    = $clog2(MAX_SIDE_DEF) + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [LETTER_W-1:0] wr_letter,
  input  logic [SW-1:0]       wr_run,
  input  logic [SW-1:0]       wr_side,
  output logic [LETTER_W-1:0] up_letter,
  output logic [SW-1:0]       up_run,
  output logic [SW-1:0]       up_side
);

  localparam int WORD_W = LETTER_W + 2 * SW;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_q_r;
  logic [WORD_W-1:0] fwd_q_r;
  logic              fwd_r;
  logic [WORD_W-1:0] wr_word;
  logic [WORD_W-1:0] word;

  assign wr_word = {wr_letter, wr_run, wr_side};

  // Memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // A read that meets a write to the same entry at the same edge sees the old
  // word, so the new word is kept aside and used instead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
    if (rd_en) begin
      fwd_q_r <= wr_word;
    end
  end

  assign word      = fwd_r ? fwd_q_r : rd_q_r;
  assign up_letter = word[WORD_W-1 -: LETTER_W];
  assign up_run    = word[2*SW-1 -: SW];
  assign up_side   = word[SW-1:0];

endmodule

FILE: hdl/fsq_tot.sv
// Per-letter running totals and the report buffer that drives the result channel.
`timescale 1ns / 1ps

module fsq_tot
  import fsq_pkg::*;
#(
  parameter int ALPHABET = ALPHABET_DEF,
  parameter int SW       = $clog2(MAX_SIDE_DEF) + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tot_req_t             req,
  input  logic [SW-1:0]        side,
  input  logic [LETTERS_W-1:0] nrep,
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LETTER_W-1:0]  out_letter_index,
  output logic [TOTAL_W-1:0]   out_square_count,
  output logic                 out_last_total
);

  localparam int LAW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

  logic [TOTAL_W-1:0]   tot_r   [ALPHABET];
  logic [TOTAL_W-1:0]   tot_nxt [ALPHABET];
  logic [TOTAL_W-1:0]   rep_r   [ALPHABET];
  logic [LETTER_W-1:0]  rep_idx_r;
  logic [LETTERS_W-1:0] rep_n_r;
  logic                 busy_r;
  logic [LAW-1:0]       idx;
  logic [TOTAL_W-1:0]   acc;
  logic                 rep_last;

  // One add on the addressed total; every other total passes through.
  assign idx = req.letter[LAW-1:0];
  assign acc = tot_r[idx] + TOTAL_W'(side);

  always_comb begin
    for (int i = 0; i < ALPHABET; i++) begin
      tot_nxt[i] = (req.add && (idx == LAW'(i))) ? acc : tot_r[i];
    end
  end

  // Totals: accumulate, and clear once copied into the report buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALPHABET; i++) begin
        tot_r[i] <= '0;
      end
    end else if (req.last) begin
      for (int i = 0; i < ALPHABET; i++) begin
        tot_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ALPHABET; i++) begin
        tot_r[i] <= tot_nxt[i];
      end
    end
  end

  assign rep_last = (LETTERS_W'(rep_idx_r) == rep_n_r - LETTERS_W'(1));

  // Report control: load on the last cell, step on each accepted result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      rep_idx_r <= '0;
      rep_n_r   <= LETTERS_W'(1);
    end else if (req.last) begin
      busy_r    <= 1'b1;
      rep_idx_r <= '0;
      rep_n_r   <= nrep;
    end else if (busy_r && !out_stall) begin
      rep_idx_r <= rep_idx_r + LETTER_W'(1);
      if (rep_last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Report buffer: a shift line whose head is the current result.
  always_ff @(posedge clk) begin
    if (req.last) begin
      for (int i = 0; i < ALPHABET; i++) begin
        rep_r[i] <= tot_nxt[i];
      end
    end else if (busy_r && !out_stall) begin
      for (int i = 0; i < ALPHABET - 1; i++) begin
        rep_r[i] <= rep_r[i+1];
      end
    end
  end

  assign busy             = busy_r;
  assign out_valid        = busy_r;
  assign out_letter_index = rep_idx_r;
  assign out_square_count = rep_r[0];
  assign out_last_total   = rep_last;

endmodule

FILE: hdl/filled_square_count_per_letter.sv
// Top level of the per-letter filled square counter.
`timescale 1ns / 1ps
//
// Cells of a square letter grid enter on the in_ channel in row-major order,
// one request per cell carrying its letter code. For each cell the block finds
// the side of the largest single-letter square ending there and adds it to
// that letter's total. After the last cell of the grid it sends one request
// per reported letter on the out_ channel (letter index, total, and a flag on
// the final one), then starts the next grid with all totals cleared.
// Throughput is one cell per cycle. The previous row lives in a line buffer
// memory with one write port and one registered read port. It is read as a cell
// is accepted and written back in the next cycle, with forwarding when the row is
// one cell wide. The first total is presented once the last cell has passed the
// update stage and loaded the report registers. The last cell of a grid is held
// off with in_stall while the previous report is still being delivered; other
// cells keep flowing. A stalled output holds its request and the buffered
// report; nothing is lost. Synchronous reset clears the counters, the totals
// and the report and restores grid_side to 16 and letters_reported to 26; the
// line buffer needs no clearing pass.
// Registers: grid_side at byte address 0, letters_reported at address 4.

module filled_square_count_per_letter
  import fsq_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Cell channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LETTER_W-1:0]   in_letter,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LETTER_W-1:0]   out_letter_index,
  output logic [TOTAL_W-1:0]    out_square_count,
  output logic                  out_last_total
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int SW = CW + 1;
  localparam logic [GRID_SIDE_W-1:0] MAX_G = GRID_SIDE_W'(MAX_SIDE);
  localparam logic [LETTERS_W-1:0]   MAX_L = LETTERS_W'(ALPHABET);

  // Configuration registers
  logic [GRID_SIDE_W-1:0] grid_side_r;
  logic [LETTERS_W-1:0]   letters_r;
  logic                   cfg_wr;

  // Position counters
  logic [CW-1:0] col_r;
  logic [CW-1:0] row_r;
  logic [CW-1:0] col_nxt;
  logic [CW-1:0] row_nxt;
  logic [SW-1:0] side_eff;
  logic          col_end;
  logic          row_end;
  logic          in_last;
  logic          in_acc;

  // Update stage
  logic                s1_v_r;
  logic [LETTER_W-1:0] s1_letter_r;
  logic [CW-1:0]       s1_col_r;
  logic                s1_c0_r;
  logic                s1_r0_r;
  logic                s1_last_r;

  // Left and diagonal neighbours
  logic [LETTER_W-1:0] left_letter_r;
  logic [SW-1:0]       hrun_r;
  logic [LETTER_W-1:0] diag_letter_r;
  logic [SW-1:0]       diag_side_r;

  // Cell arithmetic
  logic [LETTER_W-1:0] up_letter;
  logic [SW-1:0]       up_run;
  logic [SW-1:0]       up_side;
  logic [SW-1:0]       h;
  logic [SW-1:0]       v;
  logic [SW-1:0]       s;
  logic [SW:0]         diag1;
  logic [SW:0]         mn;
  logic [LETTERS_W-1:0] nrep;
  logic                 rep_busy;
  tot_req_t             req;

  // Configuration writes and reads
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r <= GRID_SIDE_W'(16);
      letters_r   <= LETTERS_W'(26);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_GRID_SIDE: grid_side_r <= pwdata[GRID_SIDE_W-1:0];
        REG_LETTERS:   letters_r   <= pwdata[LETTERS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_GRID_SIDE: prdata = APB_DATA_W'(grid_side_r);
      REG_LETTERS:   prdata = APB_DATA_W'(letters_r);
      default:       prdata = '0;
    endcase
  end

  // Effective grid side and report length, clamped to their legal ranges.
  always_comb begin
    if (grid_side_r == '0) begin
      side_eff = SW'(1);
    end else if (grid_side_r > MAX_G) begin
      side_eff = SW'(MAX_SIDE);
    end else begin
      side_eff = SW'(grid_side_r);
    end
    if (letters_r == '0) begin
      nrep = LETTERS_W'(1);
    end else if (letters_r > MAX_L) begin
      nrep = MAX_L;
    end else begin
      nrep = letters_r;
    end
  end

  // Position of the incoming cell and whether it closes the grid.
  assign col_end = ({1'b0, col_r} + SW'(1)) >= side_eff;
  assign row_end = ({1'b0, row_r} + SW'(1)) >= side_eff;
  assign in_last = col_end && row_end;
  assign col_nxt = col_end ? '0 : col_r + CW'(1);
  assign row_nxt = col_end ? (row_end ? '0 : row_r + CW'(1)) : row_r;

  // Only the closing cell waits, and only while a report is pending.
  assign in_stall = in_last && (rep_busy || (s1_v_r && s1_last_r));
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_letter_r <= in_letter;
      s1_col_r    <= col_r;
      s1_c0_r     <= (col_r == '0);
      s1_r0_r     <= (row_r == '0);
      s1_last_r   <= in_last;
    end
  end

  // Previous row, read as the cell is accepted and written back in the next cycle.
  fsq_line #(
    .DEPTH (MAX_SIDE),
    .AW    (CW),
    .SW    (SW)
  ) u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_acc),
    .rd_addr   (col_r),
    .wr_en     (s1_v_r),
    .wr_addr   (s1_col_r),
    .wr_letter (s1_letter_r),
    .wr_run    (v),
    .wr_side   (s),
    .up_letter (up_letter),
    .up_run    (up_run),
    .up_side   (up_side)
  );

  // Runs and square side of the cell in the update stage.
  always_comb begin
    h = (s1_c0_r || (left_letter_r != s1_letter_r)) ? SW'(1) : hrun_r + SW'(1);
    v = (s1_r0_r || (up_letter != s1_letter_r)) ? SW'(1) : up_run + SW'(1);
    diag1 = {1'b0, diag_side_r} + (SW+1)'(1);
    mn = diag1;
    if ({1'b0, v} < mn) begin
      mn = {1'b0, v};
    end
    if ({1'b0, h} < mn) begin
      mn = {1'b0, h};
    end
    if (s1_r0_r || s1_c0_r || (diag_letter_r != s1_letter_r)) begin
      s = SW'(1);
    end else begin
      s = mn[SW-1:0];
    end
  end

  // The cell becomes the left neighbour; the cell above becomes the diagonal.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_letter_r <= '0;
      hrun_r        <= '0;
      diag_letter_r <= '0;
      diag_side_r   <= '0;
    end else if (s1_v_r) begin
      left_letter_r <= s1_letter_r;
      hrun_r        <= h;
      diag_letter_r <= up_letter;
      diag_side_r   <= up_side;
    end
  end

  // Totals and report
  assign req.add    = s1_v_r && (s1_letter_r < LETTER_W'(ALPHABET));
  assign req.last   = s1_v_r && s1_last_r;
  assign req.letter = s1_letter_r;

  fsq_tot #(
    .ALPHABET (ALPHABET),
    .SW       (SW)
  ) u_tot (
    .clk              (clk),
    .rst_n            (rst_n),
    .req              (req),
    .side             (s),
    .nrep             (nrep),
    .busy             (rep_busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_letter_index (out_letter_index),
    .out_square_count (out_square_count),
    .out_last_total   (out_last_total)
  );

endmodule

FILE: hdl/fsq_check.sv
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps

module fsq_check
  import fsq_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input logic [LETTER_W-1:0] out_letter_index,
  input logic [TOTAL_W-1:0]  out_square_count,
  input logic                out_last_total
);

  // A stalled result request holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_square_count)
      && $stable(out_letter_index) && $stable(out_last_total))
    else $error("stalled result changed");

  // Totals of one report follow each other without gaps, letter by letter.
  a_out_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_total |=>
      out_valid && (out_letter_index == $past(out_letter_index) + LETTER_W'(1)))
    else $error("report sequence broken");

  // A report starts with the first letter.
  a_out_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_letter_index == '0)
    else $error("report does not start at letter zero");

  // Two reports never run into each other.
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_total |=> !out_valid)
    else $error("report followed without a gap");

endmodule

bind filled_square_count_per_letter fsq_check u_check (.*);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the per-letter filled square counter.
`timescale 1ns / 1ps

module testbench;
  import fsq_pkg::*;

  localparam int SIDE_W = GRID_SIDE_W;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT = 8;
  localparam int TAIL_CYCLES = 8;
  localparam int WIDE_CELLS = 40;
  localparam int RANDOM_CELLS = 130;

  // A 3x3 grid, row by row, that mixes letters, codes outside the alphabet
  // and a diagonal that holds another letter.
  localparam logic [9*LETTER_W-1:0] MIXED_GRID = {
    5'd0, 5'd0, 5'd31,
    5'd0, 5'd0, 5'd26,
    5'd1, 5'd0, 5'd0
  };

  typedef struct {
    logic [LETTER_W-1:0] letter_index;
    logic [TOTAL_W-1:0]  square_count;
    logic                last_total;
  } letter_total_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [LETTER_W-1:0]   in_letter = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [LETTER_W-1:0]   out_letter_index;
  logic [TOTAL_W-1:0]    out_square_count;
  logic                  out_last_total;

  // Cells waiting to be sent, and totals still owed by the block.
  logic [LETTER_W-1:0] cell_q[$];
  letter_total_t       owed_totals[$];
  int unsigned         mismatches = 0;
  int unsigned         cycle_count = 0;
  bit                  steady = 1'b0;

  // Register copies as the block should hold them.
  logic [SIDE_W-1:0]    side_cfg = 13'd16;
  logic [LETTERS_W-1:0] letters_cfg = 5'd26;

  // Grid walk state of the predictor.
  logic [11:0]         col_pos = '0;
  logic [11:0]         row_pos = '0;
  logic [LETTER_W-1:0] left_letter = '0;
  logic [SIDE_W-1:0]   run_left = '0;
  logic [LETTER_W-1:0] diag_letter = '0;
  logic [SIDE_W-1:0]   diag_side = '0;
  logic [LETTER_W-1:0] above_letter[MAX_SIDE_DEF];
  logic [SIDE_W-1:0]   above_run[MAX_SIDE_DEF];
  logic [SIDE_W-1:0]   above_side[MAX_SIDE_DEF];
  logic [TOTAL_W-1:0]  sums[ALPHABET_DEF];

  filled_square_count_per_letter u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_letter        (in_letter),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_letter_index (out_letter_index),
    .out_square_count (out_square_count),
    .out_last_total   (out_last_total)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit idle_roll();
    return !steady && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Scores one accepted cell and queues the report when it closes the grid.
  function automatic void score_cell(input logic [LETTER_W-1:0] letter);
    int unsigned side, col, row, h, v, s, nrep;
    logic [LETTER_W-1:0] up_letter;
    logic [SIDE_W-1:0] up_run, up_side;
    letter_total_t t;
    side = (side_cfg == 0) ? 1 : ((side_cfg > MAX_SIDE_DEF) ? MAX_SIDE_DEF : side_cfg);
    col = col_pos;
    row = row_pos;
    up_letter = above_letter[col];
    up_run = above_run[col];
    up_side = above_side[col];

    h = (col == 0 || left_letter != letter) ? 1 : run_left + 1;
    v = (row == 0 || up_letter != letter) ? 1 : up_run + 1;
    if (row == 0 || col == 0 || diag_letter != letter) begin
      s = 1;
    end else begin
      s = diag_side + 1;
      if (v < s) s = v;
      if (h < s) s = h;
    end

    // The cell above becomes the diagonal neighbour of the next cell.
    diag_letter = up_letter;
    diag_side = up_side;
    above_letter[col] = letter;
    above_run[col] = v[SIDE_W-1:0];
    above_side[col] = s[SIDE_W-1:0];
    left_letter = letter;
    run_left = h[SIDE_W-1:0];

    if (letter < ALPHABET_DEF) sums[letter] = sums[letter] + s;

    if (col + 1 >= side) begin
      col_pos = '0;
      if (row + 1 >= side) begin
        nrep = (letters_cfg == 0) ? 1 :
               ((letters_cfg > ALPHABET_DEF) ? ALPHABET_DEF : letters_cfg);
        for (int k = 0; k < nrep; k++) begin
          t.letter_index = k[LETTER_W-1:0];
          t.square_count = sums[k];
          t.last_total = (k + 1 == nrep);
          owed_totals.push_back(t);
        end
        foreach (sums[k]) sums[k] = '0;
        row_pos = '0;
      end else begin
        row_pos = row + 1;
      end
    end else begin
      col_pos = col + 1;
    end
  endfunction

  // Cell driver: scores each accepted request and loads the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) score_cell(in_letter);
      if (!in_valid || !in_stall) begin
        if (cell_q.size() != 0 && !idle_roll()) begin
          in_valid <= 1'b1;
          in_letter <= cell_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each delivered total with the oldest one owed.
  always @(posedge clk) begin : result_check
    letter_total_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (owed_totals.size() == 0) begin
        $error("unexpected total for letter %0d", out_letter_index);
        mismatches++;
      end else begin
        want = owed_totals.pop_front();
        if (out_letter_index !== want.letter_index) begin
          $error("letter_index: expected %0d, got %0d", want.letter_index, out_letter_index);
          mismatches++;
        end
        if (out_square_count !== want.square_count) begin
          $error("square_count: expected %0d, got %0d", want.square_count, out_square_count);
          mismatches++;
        end
        if (out_last_total !== want.last_total) begin
          $error("last_total: expected %0d, got %0d", want.last_total, out_last_total);
          mismatches++;
        end
      end
    end
    out_stall <= idle_roll();
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // One register transfer: setup, access, then release of the port.
  task automatic apb_cycle(input logic wr, input logic reg_idx,
                           input logic [APB_DATA_W-1:0] wdata,
                           output logic [APB_DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {reg_idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic reg_idx);
    logic [APB_DATA_W-1:0] rd;
    apb_cycle(1'b0, reg_idx, '0, rd);
    if (reg_idx == REG_GRID_SIDE) begin
      if (rd[SIDE_W-1:0] !== side_cfg) begin
        $error("grid_side: expected %0d, got %0d", side_cfg, rd[SIDE_W-1:0]);
        mismatches++;
      end
    end else if (rd[LETTERS_W-1:0] !== letters_cfg) begin
      $error("letters_reported: expected %0d, got %0d", letters_cfg, rd[LETTERS_W-1:0]);
      mismatches++;
    end
  endtask

  task automatic set_reg(input logic reg_idx, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] rd;
    apb_cycle(1'b1, reg_idx, value, rd);
    if (reg_idx == REG_GRID_SIDE) side_cfg = value[SIDE_W-1:0];
    else letters_cfg = value[LETTERS_W-1:0];
    check_reg(reg_idx);
  endtask

  // Waits until every queued cell is taken and every owed total has arrived.
  task automatic drain();
    @(posedge clk);
    while (cell_q.size() != 0 || in_valid || owed_totals.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Part of a wide first row, then the side shrinks mid-grid: the next cell
  // closes the row and four rows of five close the grid.
  task automatic wide_grid(input logic [APB_DATA_W-1:0] side_value, input bit uniform);
    set_reg(REG_GRID_SIDE, side_value);
    for (int i = 0; i < WIDE_CELLS; i++) begin
      if (uniform) cell_q.push_back(5'd7);
      else if ($urandom_range(15) == 0) cell_q.push_back($urandom_range(31));
      else cell_q.push_back($urandom_range(1));
    end
    drain();
    set_reg(REG_GRID_SIDE, 5);
    repeat (21) cell_q.push_back($urandom_range(1));
    drain();
  endtask

  // Stimulus.
  initial begin
    int unsigned side_pick, cells, base, span, random_cells;
    foreach (above_letter[i]) begin
      above_letter[i] = '0;
      above_run[i] = '0;
      above_side[i] = '0;
    end
    foreach (sums[k]) sums[k] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_reg(REG_GRID_SIDE);
    check_reg(REG_LETTERS);

    // Side zero behaves as one cell per grid; zero letters reports one total.
    set_reg(REG_GRID_SIDE, 0);
    set_reg(REG_LETTERS, 0);
    cell_q.push_back(5'd0);
    cell_q.push_back(5'd25);
    cell_q.push_back(5'd31);
    drain();

    // Letters above the alphabet are capped to a full report.
    set_reg(REG_LETTERS, 31);
    cell_q.push_back(5'd25);
    drain();

    // A uniform 3x3 grid, then one with mismatches and codes outside the alphabet.
    set_reg(REG_GRID_SIDE, 3);
    set_reg(REG_LETTERS, 26);
    repeat (9) cell_q.push_back(5'd0);
    for (int i = 0; i < 9; i++) cell_q.push_back(MIXED_GRID[(9-i)*LETTER_W-1 -: LETTER_W]);
    drain();

    // Largest side, once exact and once above range, the first without idling.
    steady = 1'b1;
    wide_grid(MAX_SIDE_DEF, 1'b1);
    steady = 1'b0;
    wide_grid(13'h1FFF, 1'b0);

    // Random grids: mostly small sides over a narrow letter set, some noise.
    random_cells = 0;
    while (random_cells < RANDOM_CELLS) begin
      case ($urandom_range(9))
        0: side_pick = 0;
        1: side_pick = 1;
        2: side_pick = $urandom_range(7, 9);
        default: side_pick = $urandom_range(2, 5);
      endcase
      set_reg(REG_GRID_SIDE, side_pick);
      set_reg(REG_LETTERS, $urandom_range(31));
      cells = (side_pick == 0) ? 1 : side_pick * side_pick;
      cells = cells * ((side_pick > 6) ? 1 : $urandom_range(1, 3));
      base = $urandom_range(25);
      span = $urandom_range(2);
      repeat (cells) begin
        if ($urandom_range(9) == 0) cell_q.push_back($urandom_range(31));
        else cell_q.push_back(base + $urandom_range(span));
      end
      random_cells += cells;
      drain();
    end

    if (mismatches == 0 && owed_totals.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: filled_square_count_per_letter.f
hdl/fsq_pkg.sv
hdl/fsq_line.sv
hdl/fsq_tot.sv
hdl/filled_square_count_per_letter.sv
hdl/fsq_check.sv
tb/sv/testbench.sv
